### hw/rtl/clc_pkg.sv
// Shared types and constants for the character display controller.
package clc_pkg;

    // Default grid size.
    localparam int ROWS_DEF = 4;
    localparam int COLS_DEF = 20;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character codes.
    localparam logic [6:0] SPACE_CHAR  = 7'h20;
    localparam logic [6:0] LAST_PRINT  = 7'h7E;

    // Control bytes of a bus write pair.
    localparam logic [7:0] CTRL_COMMAND = 8'h80;
    localparam logic [7:0] CTRL_DATA    = 8'h40;

    // Command codes.
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [4:0] CMD_FLAGS_HIGH = 5'b00001;

    // Transaction kinds on the input side.
    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_STATUS = 2'd1,
        MODE_READ   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    // Result kinds on the output side.
    typedef enum logic [2:0] {
        OUT_COMMAND = 3'd0,
        OUT_CHAR    = 3'd1,
        OUT_IGNORED = 3'd2,
        OUT_STATUS  = 3'd3,
        OUT_CELL    = 3'd4
    } outcome_t;

    // Operations handed from the front to the back.
    typedef enum logic [3:0] {
        OP_CLEAR  = 4'd0,
        OP_HOME   = 4'd1,
        OP_ADDR   = 4'd2,
        OP_FLAGS  = 4'd3,
        OP_NOP    = 4'd4,
        OP_CHAR   = 4'd5,
        OP_REPORT = 4'd6,
        OP_READ   = 4'd7
    } op_kind_t;

    // One classified operation.
    typedef struct packed {
        op_kind_t   kind;
        outcome_t   outcome;
        logic [7:0] data;
        logic [1:0] read_row;
        logic [4:0] read_col;
    } op_t;

endpackage

### hw/rtl/character_lcd_controller.sv
// Character display controller top level: front, operation queue and back.
// The back end handles each transaction in an IDLE state, which pops it, updates the cursor
// state and accesses the character store, then a FINISH state, which loads the output
// register once the output is free; no new transaction is taken until that load.
// Synchronous active-low reset homes the cursor, sets the display flag, clears the other
// flags, and marks every cell blank at once through per-cell valid bits.
module character_lcd_controller #(
    parameter int ROWS = clc_pkg::ROWS_DEF,
    parameter int COLS = clc_pkg::COLS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // ctrl byte, write byte, read row, read column
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // display address, cell character, cursor row,
                                   // cursor column, display on, cursor visible,
                                   // blink on
    output logic [2:0]  m_tuser    // outcome
);

    clc_pkg::op_t push_op;
    clc_pkg::op_t pop_op;
    logic         q_push, q_pop, q_full, q_empty;

    clc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    clc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .pop_op  (pop_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    clc_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_op     (pop_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // The back end works on one operation at a time.
    a_single_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> !q_pop)
        else $error("back end popped two operations in a row");

    // The queue is never both full and empty.
    a_queue_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_full && q_empty))
        else $error("queue reports full and empty together");

    // A result carries a defined outcome code.
    a_outcome_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= 3'(clc_pkg::OUT_CELL)))
        else $error("result outcome code out of range");

    // A cell read returns a printable character or a space.
    a_cell_printable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == 3'(clc_pkg::OUT_CELL)) |->
        (m_tdata[13:7] >= clc_pkg::SPACE_CHAR && m_tdata[13:7] <= clc_pkg::LAST_PRINT))
        else $error("cell read returned a non-printable character");

endmodule

### hw/rtl/clc_front.sv
// Front end: accepts input transactions and classifies them into operations.
module clc_front (
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,   // ctrl byte, write byte, read row, read column
    input  logic [1:0]       s_tuser,   // mode
    input  logic             q_full,
    output logic             q_push,
    output clc_pkg::op_t     q_op
);

    logic [7:0] ctrl;
    logic [7:0] data;

    assign ctrl = s_tdata[7:0];
    assign data = s_tdata[15:8];

    // Accept whenever the queue has room.
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Decode the mode and bytes into one operation.
    always_comb begin
        q_op.data     = data;
        q_op.read_row = s_tdata[17:16];
        q_op.read_col = s_tdata[22:18];
        q_op.kind     = clc_pkg::OP_REPORT;
        q_op.outcome  = clc_pkg::OUT_IGNORED;
        unique case (clc_pkg::mode_t'(s_tuser))
            clc_pkg::MODE_WRITE: begin
                if (ctrl == clc_pkg::CTRL_COMMAND) begin
                    q_op.outcome = clc_pkg::OUT_COMMAND;
                    if (data == clc_pkg::CMD_CLEAR) begin
                        q_op.kind = clc_pkg::OP_CLEAR;
                    end else if (data == clc_pkg::CMD_HOME) begin
                        q_op.kind = clc_pkg::OP_HOME;
                    end else if (data[7]) begin
                        q_op.kind = clc_pkg::OP_ADDR;
                    end else if (data[7:3] == clc_pkg::CMD_FLAGS_HIGH) begin
                        q_op.kind = clc_pkg::OP_FLAGS;
                    end else begin
                        q_op.kind = clc_pkg::OP_NOP;
                    end
                end else if (ctrl == clc_pkg::CTRL_DATA) begin
                    q_op.kind    = clc_pkg::OP_CHAR;
                    q_op.outcome = clc_pkg::OUT_CHAR;
                end
            end
            clc_pkg::MODE_STATUS: begin
                q_op.outcome = clc_pkg::OUT_STATUS;
            end
            clc_pkg::MODE_READ: begin
                q_op.kind    = clc_pkg::OP_READ;
                q_op.outcome = clc_pkg::OUT_CELL;
            end
            default: begin
                q_op.kind    = clc_pkg::OP_REPORT;
                q_op.outcome = clc_pkg::OUT_IGNORED;
            end
        endcase
    end

endmodule

### hw/rtl/clc_queue.sv
// Short operation queue between the front and the back.
module clc_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  clc_pkg::op_t push_op,
    input  logic         pop,
    output clc_pkg::op_t pop_op,
    output logic         full,
    output logic         empty
);

    clc_pkg::op_t                entry_reg [clc_pkg::QDEPTH];
    logic [clc_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [clc_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [clc_pkg::QCNT_W-1:0]  count_reg, count_next;

    assign full   = (count_reg == clc_pkg::QCNT_W'(clc_pkg::QDEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == clc_pkg::QPTR_W'(clc_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == clc_pkg::QPTR_W'(clc_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### hw/rtl/clc_back.sv
// Back end: carries out operations on the character store and cursor state.
module clc_back #(
    parameter int ROWS = clc_pkg::ROWS_DEF,
    parameter int COLS = clc_pkg::COLS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_empty,
    input  clc_pkg::op_t q_op,
    output logic         q_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,
    output logic [2:0]   m_tuser
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [2:0] ROWS_L = 3'(ROWS);
    localparam logic [5:0] COLS_L = 6'(COLS);
    localparam logic [1:0] ROW_MAX = 2'(ROWS - 1);
    localparam logic [4:0] COL_MAX = 5'(COLS - 1);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_FINISH = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    clc_pkg::op_t       op_reg, op_next;
    logic [6:0]         addr_reg, addr_next;
    logic [1:0]         row_reg, row_next;
    logic [4:0]         col_reg, col_next;
    logic               disp_reg, disp_next;
    logic               curs_reg, curs_next;
    logic               blink_reg, blink_next;
    logic [CELLS-1:0]   valid_reg, valid_next;

    logic [6:0]         mem [CELLS];
    logic [6:0]         rd_data_reg;
    logic               rd_valid_reg;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [6:0]         mem_wdata;

    logic               m_valid_reg, m_valid_next;
    logic [23:0]        m_data_reg, m_data_next;
    logic [2:0]         m_user_reg, m_user_next;

    logic               out_free;
    logic [1:0]         rd_row_sat, cmd_row_sat;
    logic [4:0]         rd_col_sat, cmd_col_sat;
    logic [5:0]         col_inc;
    logic [2:0]         row_inc;
    logic [6:0]         cell_char;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    // Saturate read and command coordinates to the grid.
    assign rd_row_sat  = ({1'b0, q_op.read_row} >= ROWS_L) ? ROW_MAX : q_op.read_row;
    assign rd_col_sat  = ({1'b0, q_op.read_col} >= COLS_L) ? COL_MAX : q_op.read_col;
    assign cmd_row_sat = ({1'b0, q_op.data[6:5]} >= ROWS_L) ? ROW_MAX : q_op.data[6:5];
    assign cmd_col_sat = ({1'b0, q_op.data[4:0]} >= COLS_L) ? COL_MAX : q_op.data[4:0];

    assign col_inc = {1'b0, col_reg} + 6'd1;
    assign row_inc = {1'b0, row_reg} + 3'd1;

    // Memory port selection for the operation being popped.
    always_comb begin
        mem_we    = q_pop && (q_op.kind == clc_pkg::OP_CHAR);
        mem_re    = q_pop && (q_op.kind == clc_pkg::OP_READ);
        mem_waddr = AW'(int'(row_reg) * COLS + int'(col_reg));
        mem_raddr = AW'(int'(rd_row_sat) * COLS + int'(rd_col_sat));
        if (q_op.data[6:0] >= clc_pkg::SPACE_CHAR && q_op.data[6:0] <= clc_pkg::LAST_PRINT
            && !q_op.data[7]) begin
            mem_wdata = q_op.data[6:0];
        end else begin
            mem_wdata = clc_pkg::SPACE_CHAR;
        end
    end

    // Cursor, address and flag updates when an operation is popped.
    always_comb begin
        op_next    = op_reg;
        addr_next  = addr_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        disp_next  = disp_reg;
        curs_next  = curs_reg;
        blink_next = blink_reg;
        valid_next = valid_reg;
        if (q_pop) begin
            op_next = q_op;
            case (q_op.kind)
                clc_pkg::OP_CLEAR: begin
                    valid_next = '0;
                    addr_next  = '0;
                    row_next   = '0;
                    col_next   = '0;
                end
                clc_pkg::OP_HOME: begin
                    addr_next = '0;
                    row_next  = '0;
                    col_next  = '0;
                end
                clc_pkg::OP_ADDR: begin
                    addr_next = q_op.data[6:0];
                    row_next  = cmd_row_sat;
                    col_next  = cmd_col_sat;
                end
                clc_pkg::OP_FLAGS: begin
                    disp_next  = q_op.data[2];
                    curs_next  = q_op.data[1];
                    blink_next = q_op.data[0];
                end
                clc_pkg::OP_CHAR: begin
                    valid_next[mem_waddr] = 1'b1;
                    if (col_inc >= COLS_L) begin
                        col_next = '0;
                        row_next = (row_inc >= ROWS_L) ? 2'd0 : row_inc[1:0];
                    end else begin
                        col_next = col_inc[4:0];
                    end
                    addr_next = {row_next, col_next};
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer and output register.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        cell_char = (op_reg.kind == clc_pkg::OP_READ) ?
                    (rd_valid_reg ? rd_data_reg : clc_pkg::SPACE_CHAR) : 7'd0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = op_reg.outcome;
                    m_data_next  = {blink_reg, curs_reg, disp_reg, col_reg, row_reg,
                                    cell_char, addr_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            addr_reg    <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            disp_reg    <= 1'b1;
            curs_reg    <= 1'b0;
            blink_reg   <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            disp_reg    <= disp_next;
            curs_reg    <= curs_next;
            blink_reg   <= blink_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // Character store: one write or one registered read per operation.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg  <= mem[mem_raddr];
            rd_valid_reg <= valid_reg[mem_raddr];
        end
    end

endmodule
